FILE: src/png_scanline_unfilter_core_defines.svh
// Assertion macros used by the port-level checker of the scanline unfilter.
`ifndef PNG_SCANLINE_UNFILTER_CORE_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PNGU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pngu check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PNGU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pngu check failed");

`endif

FILE: src/pngu_pkg.sv
// Package with the constants, codes and prediction functions of the scanline unfilter.
`default_nettype none
package pngu_pkg;

  localparam int MAX_LINE_BYTES_DFLT = 8192;
  localparam int MAX_CHANNELS_DFLT   = 4;

  localparam int BYTE_W = 8;
  localparam int BPP_W  = 3;
  localparam int LINE_W = 14;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [BPP_W-1:0]  BPP_RESET  = 3'd1;
  localparam logic [LINE_W-1:0] LINE_RESET = 14'd8192;

  localparam logic REG_BPP  = 1'b0;
  localparam logic REG_LINE = 1'b1;

  localparam logic [BYTE_W-1:0] FILT_NONE  = 8'h00;
  localparam logic [BYTE_W-1:0] FILT_SUB   = 8'h01;
  localparam logic [BYTE_W-1:0] FILT_UP    = 8'h02;
  localparam logic [BYTE_W-1:0] FILT_AVG   = 8'h03;
  localparam logic [BYTE_W-1:0] FILT_PAETH = 8'h04;

  function automatic logic signed [9:0] abs10(input logic signed [9:0] v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b,
                                               input logic [BYTE_W-1:0] c);
    logic signed [9:0] pa;
    logic signed [9:0] pb;
    logic signed [9:0] pc;
    pa = abs10($signed({2'b00, b}) - $signed({2'b00, c}));
    pb = abs10($signed({2'b00, a}) - $signed({2'b00, c}));
    pc = abs10($signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0}));
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] predict(input logic [BYTE_W-1:0] filt,
                                                 input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic [BYTE_W-1:0] c);
    logic [BYTE_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    case (filt)
      FILT_SUB:   return a;
      FILT_UP:    return b;
      FILT_AVG:   return sum[BYTE_W:1];
      FILT_PAETH: return paeth(a, b, c);
      default:    return '0;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: src/pngu_in_if.sv
// Interface for the filtered byte stream entering the unfilter.
`default_nettype none
interface pngu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered_byte;
  logic [7:0] filter_type;
  logic       image_start;

  modport source (output valid, output filtered_byte, output filter_type,
                  output image_start, input ready);
  modport sink (input valid, input filtered_byte, input filter_type,
                input image_start, output ready);
endinterface
`default_nettype wire

FILE: src/pngu_out_if.sv
// Interface for the reconstructed byte stream leaving the unfilter.
`default_nettype none
interface pngu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       bad_filter;
  logic       line_end;

  modport source (output valid, output raw_byte, output bad_filter,
                  output line_end, input ready);
  modport sink (input valid, input raw_byte, input bad_filter,
                input line_end, output ready);
endinterface
`default_nettype wire

FILE: src/pngu_slot_rem.sv
// Bit-serial remainder unit that finds the pixel slot of a column.
`default_nettype none
module pngu_slot_rem #(
  parameter int DIV_W = 13,
  parameter int REM_W = 3
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [REM_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic      [REM_W-1:0] rem
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] count;
  logic [DIV_W-1:0] quot_bits;
  logic [REM_W:0]   trial;

  assign trial = {rem, quot_bits[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_bits <= dividend;
      rem       <= '0;
    end else if (busy) begin
      quot_bits <= quot_bits << 1;
      if (trial >= {1'b0, divisor}) begin
        rem <= REM_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[REM_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/png_scanline_unfilter_core.sv
// An input byte is registered in the input stage and then in the output register.
// Throughput: one byte per clock while the output is taken and no register write is
// pending; the line store is read in the input stage, ahead of its use in the compute
// stage, and written back as the byte leaves that stage, with forwarding. A register
// write stalls the input while the pixel slot of the current column is rebuilt.
// Reset clears control state and the neighbor registers; the line store is not cleared.
`default_nettype none
module png_scanline_unfilter_core #(
  parameter int MAX_LINE_BYTES = pngu_pkg::MAX_LINE_BYTES_DFLT,
  parameter int MAX_CHANNELS   = pngu_pkg::MAX_CHANNELS_DFLT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  pngu_in_if.sink                          in_stream,
  pngu_out_if.source                       out_stream,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pngu_pkg::ADDR_W-1:0] paddr,
  input  wire logic [pngu_pkg::DATA_W-1:0] pwdata,
  output logic      [pngu_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  import pngu_pkg::*;

  localparam int CW = $clog2(MAX_LINE_BYTES);
  localparam int LW = $clog2(MAX_LINE_BYTES + 1);
  localparam int SW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int XW = (LW > LINE_W) ? LW : LINE_W;
  localparam logic [BPP_W:0] MAXCH = (BPP_W + 1)'(MAX_CHANNELS);

  logic [BPP_W-1:0]  bpp_reg;
  logic [LINE_W-1:0] line_reg;
  logic              cfg_write;
  logic              cfg_pend;
  logic [BPP_W-1:0]  bpp_eff;
  logic [LW-1:0]     len_eff;

  logic [CW-1:0]     column;
  logic              on_first_row;
  logic [SW-1:0]     slot;
  logic [BYTE_W-1:0] current_filter;

  logic              in_fire;
  logic [CW-1:0]     col0;
  logic [CW-1:0]     colc;
  logic [CW-1:0]     col_clamp;
  logic              first0;
  logic [SW-1:0]     slot0;
  logic [SW-1:0]     slot_inc;
  logic [BYTE_W-1:0] filt0;
  logic              last0;
  logic              has_left0;

  logic              rem_busy;
  logic              rem_done;
  logic [BPP_W-1:0]  rem_value;

  logic [BYTE_W-1:0] line_mem [MAX_LINE_BYTES];
  logic [BYTE_W-1:0] rd_data;

  logic              s1_valid;
  logic              s1_adv;
  logic              s1_fire;
  logic [BYTE_W-1:0] s1_x;
  logic [BYTE_W-1:0] s1_filt;
  logic [CW-1:0]     s1_col;
  logic [SW-1:0]     s1_slot;
  logic              s1_has_left;
  logic              s1_first;
  logic              s1_last;
  logic              s1_fwd;
  logic [BYTE_W-1:0] s1_fwd_data;

  logic [BYTE_W-1:0] left_bytes [MAX_CHANNELS];
  logic [BYTE_W-1:0] upper_left_bytes [MAX_CHANNELS];
  logic [BYTE_W-1:0] a1;
  logic [BYTE_W-1:0] b1;
  logic [BYTE_W-1:0] c1;
  logic [BYTE_W-1:0] raw1;

  logic              out_valid;
  logic [BYTE_W-1:0] out_raw;
  logic              out_bad;
  logic              out_last;

  // Configuration registers.
  assign cfg_write = psel & penable & pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp_reg  <= BPP_RESET;
      line_reg <= LINE_RESET;
      cfg_pend <= 1'b0;
    end else begin
      cfg_pend <= cfg_write;
      if (cfg_write) begin
        unique case (paddr[2])
          REG_BPP:  bpp_reg  <= pwdata[BPP_W-1:0];
          REG_LINE: line_reg <= pwdata[LINE_W-1:0];
          default:  bpp_reg  <= bpp_reg;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BPP:  prdata = DATA_W'(bpp_reg);
      REG_LINE: prdata = DATA_W'(line_reg);
      default:  prdata = '0;
    endcase
  end

  always_comb begin
    if (bpp_reg == '0) begin
      bpp_eff = BPP_W'(1);
    end else if ({1'b0, bpp_reg} > MAXCH) begin
      bpp_eff = BPP_W'(MAX_CHANNELS);
    end else begin
      bpp_eff = bpp_reg;
    end
    if (line_reg == '0) begin
      len_eff = LW'(1);
    end else if (XW'(line_reg) > XW'(MAX_LINE_BYTES)) begin
      len_eff = LW'(MAX_LINE_BYTES);
    end else begin
      len_eff = LW'(line_reg);
    end
  end

  // The column whose slot is rebuilt, clamped to the line end if a register write left it past.
  assign col_clamp = (LW'(column) >= len_eff) ? CW'(len_eff - LW'(1)) : column;

  pngu_slot_rem #(
    .DIV_W (CW),
    .REM_W (BPP_W)
  ) u_slot_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_pend),
    .dividend (col_clamp),
    .divisor  (bpp_eff),
    .busy     (rem_busy),
    .done     (rem_done),
    .rem      (rem_value)
  );

  // Input stage: position bookkeeping and line store read.
  assign s1_adv          = !out_valid || out_stream.ready;
  assign s1_fire         = s1_valid && s1_adv;
  assign in_stream.ready = !cfg_pend && !rem_busy && (!s1_valid || s1_adv);
  assign in_fire         = in_stream.valid && in_stream.ready;

  always_comb begin
    col0      = in_stream.image_start ? '0 : column;
    first0    = in_stream.image_start | on_first_row;
    slot0     = in_stream.image_start ? '0 : (rem_done ? SW'(rem_value) : slot);
    filt0     = (col0 == '0) ? in_stream.filter_type : current_filter;
    colc      = (LW'(col0) >= len_eff) ? CW'(len_eff - LW'(1)) : col0;
    last0     = (LW'(colc) + LW'(1)) >= len_eff;
    has_left0 = LW'(colc) >= LW'(bpp_eff);
    slot_inc  = ((BPP_W + 1)'(slot0) + (BPP_W + 1)'(1) == {1'b0, bpp_eff}) ? '0 :
                SW'(slot0 + SW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column         <= '0;
      on_first_row   <= 1'b1;
      slot           <= '0;
      current_filter <= FILT_NONE;
    end else if (in_fire) begin
      column         <= last0 ? '0 : CW'(colc + CW'(1));
      on_first_row   <= last0 ? 1'b0 : first0;
      slot           <= last0 ? '0 : slot_inc;
      current_filter <= filt0;
    end else if (rem_done) begin
      slot <= SW'(rem_value);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data <= line_mem[colc];
    end
    if (s1_fire) begin
      line_mem[s1_col] <= raw1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x        <= in_stream.filtered_byte;
      s1_filt     <= filt0;
      s1_col      <= colc;
      s1_slot     <= slot0;
      s1_has_left <= has_left0;
      s1_first    <= first0;
      s1_last     <= last0;
      s1_fwd      <= s1_fire && (s1_col == colc);
      s1_fwd_data <= raw1;
    end
  end

  // Compute stage: prediction, reconstruction and neighbor update.
  always_comb begin
    b1   = s1_first ? '0 : (s1_fwd ? s1_fwd_data : rd_data);
    a1   = s1_has_left ? left_bytes[s1_slot] : '0;
    c1   = (s1_has_left && !s1_first) ? upper_left_bytes[s1_slot] : '0;
    raw1 = s1_x + predict(s1_filt, a1, b1, c1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        left_bytes[i]       <= '0;
        upper_left_bytes[i] <= '0;
      end
    end else if (s1_fire) begin
      left_bytes[s1_slot]       <= raw1;
      upper_left_bytes[s1_slot] <= b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_raw  <= raw1;
      out_bad  <= s1_filt > FILT_PAETH;
      out_last <= s1_last;
    end
  end

  assign out_stream.valid      = out_valid;
  assign out_stream.raw_byte   = out_raw;
  assign out_stream.bad_filter = out_bad;
  assign out_stream.line_end   = out_last;

endmodule
`default_nettype wire

FILE: src/pngu_checker.sv
// Port-level checker for the scanline unfilter and its bind to the top level.
`default_nettype none
`include "png_scanline_unfilter_core_defines.svh"
module pngu_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [7:0]                  raw_byte,
  input wire logic                        bad_filter,
  input wire logic                        line_end,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic [pngu_pkg::ADDR_W-1:0] paddr,
  input wire logic [pngu_pkg::DATA_W-1:0] pwdata,
  input wire logic [pngu_pkg::DATA_W-1:0] prdata,
  input wire logic                        pready
);

  logic cfg_transfer;
  logic in_transfer;

  assign cfg_transfer = psel && penable && pwrite && pready;
  assign in_transfer  = in_valid && in_ready;

  // A stalled result holds its payload.
  `PNGU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(raw_byte) && $stable(bad_filter) && $stable(line_end))

  // A result that appears on an empty output comes from an input transfer that passed through the input stage.
  `PNGU_ASSERT_SAME(a_out_latency, $rose(out_valid), $past(in_transfer, 2))

  // A register write stalls the input while the pixel slot is rebuilt.
  `PNGU_ASSERT_NEXT(a_cfg_stall, cfg_transfer, !in_ready)

  // The pixel size register reads back what was written.
  `PNGU_ASSERT_NEXT(a_bpp_readback, cfg_transfer && !paddr[2], paddr[2] || (prdata == {29'd0, $past(pwdata[2:0])}))

endmodule

bind png_scanline_unfilter_core pngu_checker u_pngu_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_stream.valid),
  .in_ready   (in_stream.ready),
  .out_valid  (out_stream.valid),
  .out_ready  (out_stream.ready),
  .raw_byte   (out_stream.raw_byte),
  .bad_filter (out_stream.bad_filter),
  .line_end   (out_stream.line_end),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata),
  .pready     (pready)
);
`default_nettype wire
